@@ rtl/core/ps2fr_pkg.sv @@
// ----------------------------------------------------------------------------
// ps2fr_pkg
// Shared types and constants of the PS/2 frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package ps2fr_pkg;

  // packet buffer geometry
  localparam int BUFFER_DEPTH = 16;
  localparam int IDX_W        = $clog2(BUFFER_DEPTH);
  localparam logic [IDX_W-1:0] BUF_TOP = IDX_W'(BUFFER_DEPTH - 1);

  // event codes
  typedef enum logic [1:0] {
    OP_EDGE    = 2'd0,
    OP_ACK     = 2'd1,
    OP_READ    = 2'd2,
    OP_CLR_ERR = 2'd3
  } op_t;

  // receive modes
  localparam logic [1:0] MODE_CMD   = 2'd0;
  localparam logic [1:0] MODE_KBD   = 2'd1;
  localparam logic [1:0] MODE_MOUSE = 2'd2;

  // configuration register indexes
  localparam logic REG_MODE       = 1'b0;
  localparam logic REG_MOUSE_TYPE = 1'b1;

  // mouse types and their packet sizes
  localparam logic [7:0] MOUSE_TYPE_STD   = 8'h00;
  localparam logic [7:0] MOUSE_TYPE_WHEEL = 8'h03;
  localparam logic [3:0] PKT_LEN_STD      = 4'd3;
  localparam logic [3:0] PKT_LEN_WHEEL    = 4'd4;
  localparam logic [3:0] PKT_LEN_NONE     = 4'd0;

  // frame bit positions, counted from one
  localparam logic [3:0] BIT_DATA_FIRST = 4'd2;
  localparam logic [3:0] BIT_DATA_LAST  = 4'd9;
  localparam logic [3:0] BIT_PARITY     = 4'd10;
  localparam logic [3:0] BIT_STOP       = 4'd11;

  // one input event
  typedef struct packed {
    op_t        opcode;
    logic       data_bit;
    logic [3:0] read_index;
  } item_t;

  // one result
  typedef struct packed {
    logic       frame_done;
    logic [7:0] data_byte;
    logic       parity_bad;
    logic [3:0] byte_count;
    logic       packet_ready;
    logic       error_flag;
    logic       inhibit;
    logic [7:0] read_data;
  } result_t;

  // pipeline flow control from the top level to the core
  typedef struct packed {
    logic go;
    logic res_take;
  } flow_t;

endpackage

`default_nettype wire

@@ rtl/core/ps2fr_core.sv @@
// ----------------------------------------------------------------------------
// ps2fr_core
// Frame state, configuration, packet buffer and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2fr_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic                cfg_index,
  input  wire logic [7:0]          cfg_wdata,
  input  wire ps2fr_pkg::flow_t    flow,
  input  wire ps2fr_pkg::item_t    item,
  output logic                     res_vld,
  output ps2fr_pkg::result_t       res
);

  // configuration
  logic [1:0] mode_r;
  logic [7:0] mouse_type_r;

  // frame and packet state
  logic [3:0]                  bit_cnt_r, bit_cnt_nxt;
  logic [7:0]                  shift_r, shift_nxt;
  logic                        odd_r, odd_nxt;
  logic                        par_r, par_nxt;
  logic [ps2fr_pkg::IDX_W-1:0] cnt_r, cnt_nxt;
  logic                        ready_r, ready_nxt;
  logic                        err_r, err_nxt;
  logic                        inh_r, inh_nxt;

  // packet buffer
  logic [7:0] mem [ps2fr_pkg::BUFFER_DEPTH];

  // per-event working signals
  logic [3:0]                  bit_pos;
  logic [7:0]                  shift_cur;
  logic                        odd_cur;
  logic                        par_cur;
  logic [ps2fr_pkg::IDX_W-1:0] cnt_inc;
  logic [3:0]                  pkt_len;
  logic                        done, bad;
  logic [7:0]                  dbyte;
  logic                        wr_en;
  logic [ps2fr_pkg::IDX_W-1:0] wr_addr;
  logic                        rd_en;
  logic [ps2fr_pkg::IDX_W-1:0] rd_addr;

  logic    res_vld_r;
  ps2fr_pkg::result_t res_r;

  // frame start clears the assembly state
  assign shift_cur = (bit_cnt_r == 4'd0) ? 8'h00 : shift_r;
  assign odd_cur   = (bit_cnt_r == 4'd0) ? 1'b0  : odd_r;
  assign par_cur   = (bit_cnt_r == 4'd0) ? 1'b0  : par_r;
  assign bit_pos   = bit_cnt_r + 4'd1;

  // saturating store slot and count
  assign wr_addr = (cnt_r < ps2fr_pkg::BUF_TOP) ? cnt_r : ps2fr_pkg::BUF_TOP;
  assign cnt_inc = (cnt_r < ps2fr_pkg::BUF_TOP) ? cnt_r + 1'b1 : cnt_r;

  // mouse packet size
  always_comb begin
    if (mouse_type_r == ps2fr_pkg::MOUSE_TYPE_STD) begin
      pkt_len = ps2fr_pkg::PKT_LEN_STD;
    end else if (mouse_type_r == ps2fr_pkg::MOUSE_TYPE_WHEEL) begin
      pkt_len = ps2fr_pkg::PKT_LEN_WHEEL;
    end else begin
      pkt_len = ps2fr_pkg::PKT_LEN_NONE;
    end
  end

  // event decode and next state
  always_comb begin
    bit_cnt_nxt = bit_cnt_r;
    shift_nxt   = shift_r;
    odd_nxt     = odd_r;
    par_nxt     = par_r;
    cnt_nxt     = cnt_r;
    ready_nxt   = ready_r;
    err_nxt     = err_r;
    inh_nxt     = inh_r;
    done        = 1'b0;
    bad         = 1'b0;
    dbyte       = 8'h00;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = item.read_index[ps2fr_pkg::IDX_W-1:0];
    unique case (item.opcode)
      ps2fr_pkg::OP_EDGE: begin
        if (!inh_r) begin
          bit_cnt_nxt = bit_pos;
          shift_nxt   = shift_cur;
          odd_nxt     = odd_cur;
          par_nxt     = par_cur;
          if (bit_pos >= ps2fr_pkg::BIT_DATA_FIRST &&
              bit_pos <= ps2fr_pkg::BIT_DATA_LAST) begin
            shift_nxt = {item.data_bit, shift_cur[7:1]};
            odd_nxt   = odd_cur ^ item.data_bit;
          end else if (bit_pos == ps2fr_pkg::BIT_PARITY) begin
            par_nxt = item.data_bit;
          end else if (bit_pos == ps2fr_pkg::BIT_STOP) begin
            done        = 1'b1;
            dbyte       = shift_cur;
            bit_cnt_nxt = 4'd0;
            if (odd_cur ^ par_cur) begin
              // good byte: store and maybe flag the packet
              wr_en   = 1'b1;
              cnt_nxt = cnt_inc;
              if (mode_r == ps2fr_pkg::MODE_CMD) begin
                ready_nxt = 1'b1;
                inh_nxt   = 1'b1;
              end else if (mode_r == ps2fr_pkg::MODE_MOUSE &&
                           pkt_len != ps2fr_pkg::PKT_LEN_NONE &&
                           4'(cnt_inc) == pkt_len) begin
                ready_nxt = 1'b1;
                inh_nxt   = 1'b1;
              end
            end else begin
              bad     = 1'b1;
              err_nxt = 1'b1;
              cnt_nxt = '0;
            end
          end
        end
      end
      ps2fr_pkg::OP_ACK: begin
        if (ready_r) begin
          rd_en     = (cnt_r != '0);
          rd_addr   = cnt_r - 1'b1;
          cnt_nxt   = '0;
          ready_nxt = 1'b0;
        end
        inh_nxt = 1'b0;
      end
      ps2fr_pkg::OP_READ: begin
        rd_en = (int'(item.read_index) < ps2fr_pkg::BUFFER_DEPTH);
      end
      ps2fr_pkg::OP_CLR_ERR: begin
        err_nxt = 1'b0;
      end
      default: begin
        err_nxt = err_r;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= ps2fr_pkg::MODE_CMD;
      mouse_type_r <= ps2fr_pkg::MOUSE_TYPE_STD;
      bit_cnt_r    <= '0;
      shift_r      <= '0;
      odd_r        <= 1'b0;
      par_r        <= 1'b0;
      cnt_r        <= '0;
      ready_r      <= 1'b0;
      err_r        <= 1'b0;
      inh_r        <= 1'b0;
      res_vld_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == ps2fr_pkg::REG_MODE) begin
          mode_r <= cfg_wdata[1:0];
        end else begin
          mouse_type_r <= cfg_wdata;
        end
      end
      if (flow.go) begin
        bit_cnt_r <= bit_cnt_nxt;
        shift_r   <= shift_nxt;
        odd_r     <= odd_nxt;
        par_r     <= par_nxt;
        cnt_r     <= cnt_nxt;
        ready_r   <= ready_nxt;
        err_r     <= err_nxt;
        inh_r     <= inh_nxt;
        res_vld_r <= 1'b1;
      end else if (flow.res_take) begin
        res_vld_r <= 1'b0;
      end
    end
  end

  // buffer write and registered result with buffer read
  always_ff @(posedge clk) begin
    if (flow.go) begin
      if (wr_en) begin
        mem[wr_addr] <= shift_cur;
      end
      res_r.frame_done   <= done;
      res_r.data_byte    <= dbyte;
      res_r.parity_bad   <= bad;
      res_r.byte_count   <= 4'(cnt_nxt);
      res_r.packet_ready <= ready_nxt;
      res_r.error_flag   <= err_nxt;
      res_r.inhibit      <= inh_nxt;
      res_r.read_data    <= rd_en ? mem[rd_addr] : 8'h00;
    end
  end

  assign res_vld = res_vld_r;
  assign res     = res_r;

endmodule

`default_nettype wire

@@ rtl/core/ps2fr_out_q.sv @@
// ----------------------------------------------------------------------------
// ps2fr_out_q
// Two-entry result queue that decouples the core from output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2fr_out_q (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire ps2fr_pkg::result_t  push_data,
  output logic                     full,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output ps2fr_pkg::result_t       head
);

  ps2fr_pkg::result_t q_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign out_valid = (cnt_r != 2'd0);
  assign full      = (cnt_r == 2'd2);
  assign pop       = out_valid && !out_stall;
  assign head      = q_r[rd_ptr_r];

  // occupancy
  always_comb begin
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  // entries
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/ps2_frame_receiver.sv @@
// ----------------------------------------------------------------------------
// ps2_frame_receiver
// PS/2 device frame receiver: frame assembly, parity check, packet buffer.
// ----------------------------------------------------------------------------
//   port group  | direction | handshake          | contents
//   in_*        | input     | in_valid/in_stall  | opcode, data_bit, read_index
//   out_*       | output    | out_valid/out_stall| frame and packet status
//   cfg_*       | input     | cfg_we             | mode, mouse_type
//
// One event per clock sustained while in_stall is low; the core's state
// update is combinational into its state registers. out_valid follows the
// input transfer through the input register, the result register and the
// output queue. The output queue holds two results, so the input keeps
// moving while one result waits. Reset is synchronous and needs no sweep;
// packet buffer contents are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2_frame_receiver (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // configuration
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [7:0] cfg_wdata,
  // events
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] in_opcode,
  input  wire logic       in_data_bit,
  input  wire logic [3:0] in_read_index,
  // results
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_frame_done,
  output logic [7:0]      out_data_byte,
  output logic            out_parity_bad,
  output logic [3:0]      out_byte_count,
  output logic            out_packet_ready,
  output logic            out_error_flag,
  output logic            out_inhibit,
  output logic [7:0]      out_read_data
);

  logic               in_vld_r;
  ps2fr_pkg::item_t   in_item_r;
  logic               in_xfer;
  logic               res_vld;
  ps2fr_pkg::result_t res;
  logic               q_full;
  ps2fr_pkg::flow_t   flow;
  ps2fr_pkg::result_t head;

  // pipeline advance
  assign flow.res_take = res_vld && !q_full;
  assign flow.go       = in_vld_r && (!res_vld || flow.res_take);
  assign in_stall      = in_vld_r && !flow.go;
  assign in_xfer       = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_xfer) begin
      in_vld_r <= 1'b1;
    end else if (flow.go) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_item_r.opcode     <= ps2fr_pkg::op_t'(in_opcode);
      in_item_r.data_bit   <= in_data_bit;
      in_item_r.read_index <= in_read_index;
    end
  end

  // receiver core
  ps2fr_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .flow      (flow),
    .item      (in_item_r),
    .res_vld   (res_vld),
    .res       (res)
  );

  // result queue
  ps2fr_out_q u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (flow.res_take),
    .push_data (res),
    .full      (q_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  // result fields
  assign out_frame_done   = head.frame_done;
  assign out_data_byte    = head.data_byte;
  assign out_parity_bad   = head.parity_bad;
  assign out_byte_count   = head.byte_count;
  assign out_packet_ready = head.packet_ready;
  assign out_error_flag   = head.error_flag;
  assign out_inhibit      = head.inhibit;
  assign out_read_data    = head.read_data;

endmodule

`default_nettype wire

@@ rtl/core/ps2fr_checker.sv @@
// ----------------------------------------------------------------------------
// ps2fr_checker
// Port-level checks of the PS/2 frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2fr_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       out_frame_done,
  input wire logic [7:0] out_data_byte,
  input wire logic       out_parity_bad,
  input wire logic [3:0] out_byte_count,
  input wire logic       out_packet_ready,
  input wire logic       out_error_flag,
  input wire logic       out_inhibit,
  input wire logic [7:0] out_read_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data_byte) &&
      $stable(out_read_data) && $stable(out_byte_count))
    else $error("stalled result changed");

  // a flagged packet always holds the clock inhibited
  a_ready_inh: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_packet_ready |-> out_inhibit)
    else $error("packet ready without inhibit");

  // parity failure sets the error flag and clears the byte count
  a_bad_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_parity_bad |->
      out_frame_done && out_error_flag && out_byte_count == 4'd0)
    else $error("parity failure not reflected in status");

  // byte and parity fields only carry a completed frame
  a_no_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_frame_done |-> out_data_byte == 8'h00 && !out_parity_bad)
    else $error("frame fields set without a completed frame");

  // a clock edge never returns buffer data
  a_frame_rd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_done |-> out_read_data == 8'h00)
    else $error("read data on a frame result");

endmodule

bind ps2_frame_receiver ps2fr_checker u_ps2fr_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_frame_done   (out_frame_done),
  .out_data_byte    (out_data_byte),
  .out_parity_bad   (out_parity_bad),
  .out_byte_count   (out_byte_count),
  .out_packet_ready (out_packet_ready),
  .out_error_flag   (out_error_flag),
  .out_inhibit      (out_inhibit),
  .out_read_data    (out_read_data)
);

`default_nettype wire

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for ps2_frame_receiver. Frames, acknowledges, buffer
// reads and error clears are queued by the stimulus process together with the
// status each one should produce. A clocked driver feeds the event port with
// random gaps. A clocked monitor applies random stall bursts and checks every
// result against the oldest predicted status. Each configuration phase first
// writes its mode and mouse type.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import ps2fr_pkg::*;

  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int         HOLD_AT    = 150;
  localparam int         HOLD_LEN   = 90;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic       cfg_index = REG_MODE;
  logic [7:0] cfg_wdata = 8'h00;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] in_opcode = OP_EDGE;
  logic       in_data_bit = 1'b0;
  logic [3:0] in_read_index = 4'h0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_frame_done;
  logic [7:0] out_data_byte;
  logic       out_parity_bad;
  logic [3:0] out_byte_count;
  logic       out_packet_ready;
  logic       out_error_flag;
  logic       out_inhibit;
  logic [7:0] out_read_data;

  ps2_frame_receiver dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_data_bit      (in_data_bit),
    .in_read_index    (in_read_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_frame_done   (out_frame_done),
    .out_data_byte    (out_data_byte),
    .out_parity_bad   (out_parity_bad),
    .out_byte_count   (out_byte_count),
    .out_packet_ready (out_packet_ready),
    .out_error_flag   (out_error_flag),
    .out_inhibit      (out_inhibit),
    .out_read_data    (out_read_data)
  );

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // pending events and predicted status words
  item_t   event_q[$];
  result_t status_q[$];

  int mismatches   = 0;
  int results_seen = 0;
  int phase_items  = 0;
  bit quiet        = 1'b0;

  // receiver shadow state
  logic [1:0]  m_mode;
  logic [7:0]  m_mouse_type;
  logic [3:0]  m_bitcnt;
  logic [7:0]  m_shift;
  logic [3:0]  m_ones;
  logic        m_par;
  logic [7:0]  m_buf [BUFFER_DEPTH];
  logic [15:0] m_written;
  logic [3:0]  m_count;
  logic        m_ready;
  logic        m_perr;
  logic        m_inhibit;

  // buffer a good byte and raise ready where the mode asks for it
  function automatic void store_byte(logic [7:0] value);
    logic [3:0] slot;
    logic [3:0] need;
    slot = (m_count < BUF_TOP) ? m_count : BUF_TOP;
    m_buf[slot] = value;
    m_written[slot] = 1'b1;
    if (m_count < BUF_TOP) m_count = m_count + 4'd1;
    if (m_mode == MODE_CMD) begin
      m_ready = 1'b1;
      m_inhibit = 1'b1;
    end else if (m_mode == MODE_MOUSE) begin
      need = (m_mouse_type == MOUSE_TYPE_STD)   ? PKT_LEN_STD :
             (m_mouse_type == MOUSE_TYPE_WHEEL) ? PKT_LEN_WHEEL : PKT_LEN_NONE;
      if (need != PKT_LEN_NONE && m_count == need) begin
        m_ready = 1'b1;
        m_inhibit = 1'b1;
      end
    end
  endfunction

  // status word for one event, advancing the shadow state
  function automatic result_t predict_status(item_t ev);
    result_t r;
    r = '0;
    case (ev.opcode)
      OP_EDGE: begin
        if (!m_inhibit) begin
          if (m_bitcnt == 4'd0) begin
            m_shift = 8'h00;
            m_ones = 4'd0;
            m_par = 1'b0;
          end
          m_bitcnt = m_bitcnt + 4'd1;
          if (m_bitcnt >= BIT_DATA_FIRST && m_bitcnt <= BIT_DATA_LAST) begin
            m_shift = {ev.data_bit, m_shift[7:1]};
            m_ones = m_ones + {3'b000, ev.data_bit};
          end else if (m_bitcnt == BIT_PARITY) begin
            m_par = ev.data_bit;
          end else if (m_bitcnt == BIT_STOP) begin
            r.frame_done = 1'b1;
            r.data_byte = m_shift;
            if (m_ones[0] ^ m_par) begin
              store_byte(m_shift);
            end else begin
              r.parity_bad = 1'b1;
              m_perr = 1'b1;
              m_count = 4'd0;
            end
            m_bitcnt = 4'd0;
          end
        end
      end
      OP_ACK: begin
        if (m_ready) begin
          if (m_count != 4'd0) r.read_data = m_buf[m_count - 4'd1];
          m_count = 4'd0;
          m_ready = 1'b0;
        end
        m_inhibit = 1'b0;
      end
      OP_READ: begin
        if (int'(ev.read_index) < BUFFER_DEPTH) r.read_data = m_buf[ev.read_index];
      end
      default: begin
        m_perr = 1'b0;
      end
    endcase
    r.byte_count = m_count;
    r.packet_ready = m_ready;
    r.error_flag = m_perr;
    r.inhibit = m_inhibit;
    return r;
  endfunction

  // queue one event; reads are steered onto entries that hold data, or become error clears while none do
  task automatic queue_event(input op_t op, input logic b, input logic [3:0] idx);
    item_t ev;
    ev.opcode = op;
    ev.data_bit = b;
    ev.read_index = idx;
    if (op == OP_READ && !m_written[idx]) begin
      if (m_written == 16'h0000) begin
        ev.opcode = OP_CLR_ERR;
      end else begin
        while (!m_written[ev.read_index]) ev.read_index = 4'($urandom);
      end
    end
    if (!(ev.opcode == OP_EDGE && m_inhibit)) phase_items++;
    status_q.push_back(predict_status(ev));
    event_q.push_back(ev);
  endtask

  // one well-formed frame, first acknowledging an inhibit and bringing the bit count back in line
  task automatic queue_frame(input logic [7:0] value, input bit good);
    logic par;
    if (m_inhibit) queue_event(OP_ACK, 1'($urandom), 4'($urandom));
    while (m_bitcnt != 4'd0) queue_event(OP_EDGE, 1'($urandom), 4'($urandom));
    par = good ? ~^value : ^value;
    queue_event(OP_EDGE, 1'($urandom), 4'($urandom));
    for (int i = 0; i < 8; i++) queue_event(OP_EDGE, value[i], 4'($urandom));
    queue_event(OP_EDGE, par, 4'($urandom));
    queue_event(OP_EDGE, 1'($urandom), 4'($urandom));
  endtask

  // mostly frames with follow-up traffic, the rest noise
  task automatic queue_random_step();
    int pick;
    int n;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      queue_frame(8'($urandom), $urandom_range(0, 9) != 0);
      if (m_inhibit) begin
        n = $urandom_range(0, 2);
        repeat (n) queue_event(OP_READ, 1'($urandom), 4'($urandom));
        if ($urandom_range(0, 19) != 0) queue_event(OP_ACK, 1'($urandom), 4'($urandom));
      end
    end else if (pick < 70) begin
      queue_event(OP_READ, 1'($urandom), 4'($urandom));
    end else if (pick < 76) begin
      queue_event(OP_CLR_ERR, 1'($urandom), 4'($urandom));
    end else if (pick < 82) begin
      queue_event(OP_ACK, 1'($urandom), 4'($urandom));
    end else if (pick < 92) begin
      queue_event(OP_EDGE, 1'($urandom), 4'($urandom));
    end else begin
      queue_event(op_t'(2'($urandom)), 1'($urandom), 4'($urandom));
    end
  endtask

  // register write, only while idle
  task automatic write_reg(input logic idx, input logic [7:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MODE) m_mode = value[1:0];
    else m_mouse_type = value;
  endtask

  // hold the sender until every result is back, plus the pipeline depth
  task automatic wait_drained();
    while (event_q.size() != 0 || status_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic run_phase(input logic [1:0] mode, input logic [7:0] id,
                           input int budget, input bit fill);
    write_reg(REG_MODE, {6'd0, mode});
    write_reg(REG_MOUSE_TYPE, id);
    phase_items = 0;
    // enough good bytes to write every entry and saturate the count
    if (fill) repeat (BUFFER_DEPTH + 1) queue_frame(8'($urandom), 1'b1);
    while (phase_items < budget) queue_random_step();
    wait_drained();
  endtask

  // event driver
  item_t drive_item;
  int    in_gap = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_gap > 0) begin
        in_gap = in_gap - 1;
        in_valid <= 1'b0;
      end else if (event_q.size() > 0) begin
        drive_item = event_q.pop_front();
        in_valid <= 1'b1;
        in_opcode <= drive_item.opcode;
        in_data_bit <= drive_item.data_bit;
        in_read_index <= drive_item.read_index;
        if (!quiet && $urandom_range(0, 9) == 0) in_gap = $urandom_range(1, 14);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // result monitor and stall generator
  result_t want;
  int      stall_left = 0;
  int      hold_left  = 0;
  bit      hold_done  = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (status_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual byte_count %0h",
                   $time, out_byte_count);
          mismatches++;
        end else begin
          want = status_q.pop_front();
          check_field("frame_done", want.frame_done, out_frame_done);
          check_field("data_byte", want.data_byte, out_data_byte);
          check_field("parity_bad", want.parity_bad, out_parity_bad);
          check_field("byte_count", want.byte_count, out_byte_count);
          check_field("packet_ready", want.packet_ready, out_packet_ready);
          check_field("error_flag", want.error_flag, out_error_flag);
          check_field("inhibit", want.inhibit, out_inhibit);
          check_field("read_data", want.read_data, out_read_data);
        end
        results_seen++;
      end
      // one long hold-off so the block backs up into its input
      if (results_seen >= HOLD_AT && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_stall <= 1'b1;
      end else if (!quiet && stall_left > 0) begin
        stall_left = stall_left - 1;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 14) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // stimulus and end of run
  initial begin
    m_mode = MODE_CMD;
    m_mouse_type = MOUSE_TYPE_STD;
    m_bitcnt = 4'd0;
    m_shift = 8'h00;
    m_ones = 4'd0;
    m_par = 1'b0;
    m_written = 16'h0000;
    m_count = 4'd0;
    m_ready = 1'b0;
    m_perr = 1'b0;
    m_inhibit = 1'b0;
    for (int i = 0; i < BUFFER_DEPTH; i++) m_buf[i] = 8'h00;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: all-ones byte, edge while inhibited, acknowledge, read,
    // failing parity on an all-zero byte, error clear
    write_reg(REG_MODE, {6'd0, MODE_CMD});
    write_reg(REG_MOUSE_TYPE, MOUSE_TYPE_STD);
    queue_frame(8'hff, 1'b1);
    queue_event(OP_EDGE, 1'b1, 4'hf);
    queue_event(OP_ACK, 1'b0, 4'h0);
    queue_event(OP_READ, 1'b1, 4'h0);
    queue_frame(8'h00, 1'b0);
    queue_event(OP_CLR_ERR, 1'b1, 4'hf);
    wait_drained();

    // keyboard first so the whole buffer gets written and the count saturates
    run_phase(MODE_KBD, MOUSE_TYPE_STD, 100, 1'b1);
    run_phase(MODE_MOUSE, MOUSE_TYPE_STD, 90, 1'b0);
    run_phase(MODE_MOUSE, MOUSE_TYPE_WHEEL, 90, 1'b0);
    run_phase(MODE_CMD, 8'hff, 90, 1'b0);
    run_phase(MODE_SPARE, MOUSE_TYPE_WHEEL, 90, 1'b0);
    run_phase(MODE_MOUSE, 8'hff, 90, 1'b0);
    run_phase(MODE_MOUSE, 8'($urandom_range(4, 254)), 90, 1'b0);
    quiet = 1'b1;
    run_phase(MODE_MOUSE, MOUSE_TYPE_STD, 90, 1'b0);

    repeat (10) @(posedge clk);
    if (status_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, status_q.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #600000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

`default_nettype wire
